// ----- sv/kpsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpsd_pkg: shared definitions for the keypad scanner
// Matrix geometry, key queue sizing, register indexes and the command that
// passes from the scan front end to the key queue back end.
// ----------------------------------------------------------------------------
package kpsd_pkg;

    localparam int ROWS        = 4;
    localparam int COLS        = 4;
    localparam int KEYS        = 16;  // width of the matrix snapshot field
    localparam int QUEUE_DEPTH = 16;

    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int QCNT_W  = 5;       // width of the queue_count field
    localparam int CODE_W  = 8;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [CODE_W-1:0] RELEASE_FLAG = 8'h80;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POLL_PERIOD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_POLLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_EVENTS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEYMAP_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEYMAP_HIGH    = 3'd4;

    // Reset values of the configuration registers
    localparam logic [7:0]       RST_POLL_PERIOD    = 8'd10;
    localparam logic [7:0]       RST_DEBOUNCE_POLLS = 8'd5;
    localparam logic             RST_RELEASE_EVENTS = 1'b1;
    localparam logic [CFG_W-1:0] RST_KEYMAP_LOW     = 64'h0807060504030201;
    localparam logic [CFG_W-1:0] RST_KEYMAP_HIGH    = 64'h100F0E0D0C0B0A09;

    // One queued operation for the back end
    typedef struct packed {
        logic              is_read;   // pop one code
        logic              push_en;   // push code (ignored on a pop)
        logic [CODE_W-1:0] code;
    } t_cmd;

endpackage

// ----- sv/kpsd_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpsd_in_if: request channel of the keypad scanner
// Carries a tick with a matrix snapshot or a read request.
// ----------------------------------------------------------------------------
interface kpsd_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] key_matrix;

    modport source (output valid, output action, output key_matrix, input ready);
    modport sink   (input valid, input action, input key_matrix, output ready);
endinterface

// ----- sv/kpsd_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpsd_out_if: result channel of the keypad scanner
// Carries the popped code, its valid flag, the queue level and overflow.
// ----------------------------------------------------------------------------
interface kpsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_code;
    logic       key_valid;
    logic [4:0] queue_count;
    logic       overflow;

    modport source (output valid, output key_code, output key_valid,
                    output queue_count, output overflow, input ready);
    modport sink   (input valid, input key_code, input key_valid,
                    input queue_count, input overflow, output ready);
endinterface

// ----- sv/kpsd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpsd_front: tick divider, matrix scan and debounce
// Holds the configuration registers, counts ticks, scans the snapshot on a
// poll and decides which code, if any, goes to the key queue.
// ----------------------------------------------------------------------------
module kpsd_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [kpsd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kpsd_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_accept,
    input  logic                           i_action,
    input  logic [kpsd_pkg::KEYS-1:0]      i_key_matrix,
    output kpsd_pkg::t_cmd                 o_cmd
);
    import kpsd_pkg::*;

    logic [7:0]       r_poll_period;
    logic [7:0]       r_debounce_polls;
    logic             r_release_events;
    logic [CFG_W-1:0] r_keymap_low;
    logic [CFG_W-1:0] r_keymap_high;

    logic [7:0]        r_tick, n_tick;
    logic [7:0]        r_bounce, n_bounce;
    logic [CODE_W-1:0] r_held, n_held;

    logic [7:0]        tick_dec;
    logic [7:0]        bounce_dec;
    logic [CODE_W-1:0] scan_key;

    // First pressed key per column decides that column; a zero code
    // abandons the column and the search moves to the next one.
    function automatic logic [CODE_W-1:0] scan_code(
        input logic [KEYS-1:0]    m,
        input logic [2*CFG_W-1:0] km
    );
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] c8;
        logic              found;
        logic              col_done;
        code  = '0;
        found = 1'b0;
        for (int c = 0; c < COLS; c++) begin
            col_done = 1'b0;
            for (int r = 0; r < ROWS; r++) begin
                if (!found && !col_done && m[c*ROWS + r]) begin
                    c8       = km[(c*ROWS + r)*CODE_W +: CODE_W];
                    col_done = 1'b1;
                    if (c8 != '0) begin
                        code  = c8;
                        found = 1'b1;
                    end
                end
            end
        end
        return code;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_period    <= RST_POLL_PERIOD;
            r_debounce_polls <= RST_DEBOUNCE_POLLS;
            r_release_events <= RST_RELEASE_EVENTS;
            r_keymap_low     <= RST_KEYMAP_LOW;
            r_keymap_high    <= RST_KEYMAP_HIGH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_POLL_PERIOD:    r_poll_period    <= i_cfg_data[7:0];
                REG_DEBOUNCE_POLLS: r_debounce_polls <= i_cfg_data[7:0];
                REG_RELEASE_EVENTS: r_release_events <= i_cfg_data[0];
                REG_KEYMAP_LOW:     r_keymap_low     <= i_cfg_data;
                REG_KEYMAP_HIGH:    r_keymap_high    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign tick_dec   = r_tick - 8'd1;
    assign bounce_dec = r_bounce - 8'd1;
    assign scan_key   = scan_code(i_key_matrix, {r_keymap_high, r_keymap_low});

    always_comb begin
        n_tick        = r_tick;
        n_bounce      = r_bounce;
        n_held        = r_held;
        o_cmd.is_read = i_action;
        o_cmd.push_en = 1'b0;
        o_cmd.code    = scan_key;
        if (!i_action) begin
            if (tick_dec == 8'd0) begin
                n_tick = r_poll_period;
                if (scan_key == '0) begin
                    if (r_bounce != 8'd0) begin
                        n_bounce = bounce_dec;
                        if (bounce_dec == 8'd0) begin
                            o_cmd.push_en = r_release_events;
                            o_cmd.code    = r_held | RELEASE_FLAG;
                            n_held        = '0;
                        end
                    end
                end else begin
                    n_bounce = r_debounce_polls;
                    if (r_held != scan_key) begin
                        n_held        = scan_key;
                        o_cmd.push_en = 1'b1;
                    end
                end
            end else begin
                n_tick = tick_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= RST_POLL_PERIOD;
            r_bounce <= '0;
            r_held   <= '0;
        end else if (i_accept) begin
            r_tick   <= n_tick;
            r_bounce <= n_bounce;
            r_held   <= n_held;
        end
    end

endmodule

// ----- sv/kpsd_cmd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpsd_cmd_fifo: two-entry command queue
// Decouples the scan front end from the key queue back end.
// ----------------------------------------------------------------------------
module kpsd_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_en,
    input  kpsd_pkg::t_cmd i_wr_cmd,
    output logic           o_full,
    input  logic           i_rd_en,
    output logic           o_rd_valid,
    output kpsd_pkg::t_cmd o_rd_cmd
);
    import kpsd_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full     = (r_cnt == 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wp] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr_en) begin
                r_wp <= ~r_wp;
            end
            if (i_rd_en) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_wr_en) - 2'(i_rd_en);
        end
    end

endmodule

// ----- sv/kpsd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpsd_back: key queue and result register
// Executes push and pop commands in order against the key queue and
// registers one result per command.
// ----------------------------------------------------------------------------
module kpsd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  kpsd_pkg::t_cmd i_cmd,
    output logic           o_cmd_take,
    kpsd_out_if.source     o_res
);
    import kpsd_pkg::*;

    logic [CODE_W-1:0] r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_idx, n_wr_idx;
    logic [QPTR_W-1:0] r_rd_idx, n_rd_idx;
    logic [FILL_W-1:0] r_fill, n_fill;

    logic              r_out_valid;
    logic [CODE_W-1:0] r_code;
    logic              r_kvalid, n_kvalid;
    logic              r_ovf, n_ovf;
    logic              q_write;

    function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    // The result register may be refilled in the cycle it is taken.
    assign o_cmd_take = i_cmd_valid && (!r_out_valid || o_res.ready);

    always_comb begin
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_fill   = r_fill;
        n_kvalid = 1'b0;
        n_ovf    = 1'b0;
        q_write  = 1'b0;
        if (i_cmd.is_read) begin
            if (r_fill != '0) begin
                n_kvalid = 1'b1;
                n_rd_idx = ptr_next(r_rd_idx);
                n_fill   = r_fill - FILL_W'(1);
            end
        end else if (i_cmd.push_en) begin
            if (r_fill == FILL_W'(QUEUE_DEPTH)) begin
                n_ovf = 1'b1;
            end else begin
                q_write  = 1'b1;
                n_wr_idx = ptr_next(r_wr_idx);
                n_fill   = r_fill + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take && q_write) begin
            r_queue[r_wr_idx] <= i_cmd.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd_take) begin
                r_wr_idx    <= n_wr_idx;
                r_rd_idx    <= n_rd_idx;
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_code   <= n_kvalid ? r_queue[r_rd_idx] : '0;
            r_kvalid <= n_kvalid;
            r_ovf    <= n_ovf;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.key_code    = r_code;
    assign o_res.key_valid   = r_kvalid;
    assign o_res.queue_count = QCNT_W'(r_fill);
    assign o_res.overflow    = r_ovf;

endmodule

// ----- sv/keypad_scan_debounce_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_scan_debounce_fifo: matrix keypad scanner with debounce and queue
// Every request on i_key is either a tick carrying a 16-bit snapshot of the
// key matrix (action 0) or a read of the key queue (action 1). Each request
// gives exactly one result on o_key: the popped code and its valid flag,
// the number of codes left in the queue and an overflow flag that marks a
// code dropped because the 16-entry queue was full.
// The front end updates the tick divider, scan and debounce state in the
// cycle a request is accepted; the command then passes through the command
// queue, and the back end applies the push or pop when it takes the command
// and registers the result. Up to one request is accepted every cycle while
// the command queue is not full; the scan is combinational.
// A two-entry command queue sits between the two halves, so a stalled
// result channel holds i_key.ready low only once that queue is full.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while the
// block is idle. Reset (i_rst_n low, synchronous) restores the register
// defaults, empties both queues and clears the debounce state.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_fifo (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [kpsd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kpsd_pkg::CFG_W-1:0]     i_cfg_data,
    kpsd_in_if.sink                        i_key,
    kpsd_out_if.source                     o_key
);
    import kpsd_pkg::*;

    t_cmd front_cmd;
    t_cmd back_cmd;
    logic in_accept;
    logic cmd_full;
    logic cmd_valid;
    logic cmd_take;

    assign i_key.ready = !cmd_full;
    assign in_accept   = i_key.valid && !cmd_full;

    kpsd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (in_accept),
        .i_action     (i_key.action),
        .i_key_matrix (i_key.key_matrix),
        .o_cmd        (front_cmd)
    );

    kpsd_cmd_fifo u_cmd_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (in_accept),
        .i_wr_cmd   (front_cmd),
        .o_full     (cmd_full),
        .i_rd_en    (cmd_take),
        .o_rd_valid (cmd_valid),
        .o_rd_cmd   (back_cmd)
    );

    kpsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (back_cmd),
        .o_cmd_take  (cmd_take),
        .o_res       (o_key)
    );

endmodule

// ----- tb/keypad_scan_debounce_fifo_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_scan_debounce_fifo_tb: self-checking bench for the keypad scanner
// Sends tick and read requests with random gaps and result back-pressure.
// A local model of the scan divider, the debounce state and the key queue
// predicts every result, which is compared field by field. Power-on values,
// zero codes, zero debounce, release codes on and off, a full queue and a
// zero poll period are all exercised across many register settings.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_fifo_tb;
    import kpsd_pkg::*;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_READ = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int IDLE_PCT    = 29;
    localparam int SETTLE      = 6;
    localparam int DRAIN_LIMIT = 5000;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [CODE_W-1:0] key_code;
        logic              key_valid;
        logic [QCNT_W-1:0] queue_count;
        logic              overflow;
    } t_key_report;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    kpsd_in_if  key_in ();
    kpsd_out_if key_out ();

    keypad_scan_debounce_fifo dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_key      (key_in),
        .o_key      (key_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Local copy of the registers and of the scanner state.
    logic [7:0]        cfg_poll;
    logic [7:0]        cfg_debounce;
    logic              cfg_release;
    logic [CFG_W-1:0]  cfg_map_lo;
    logic [CFG_W-1:0]  cfg_map_hi;
    logic [7:0]        scan_ticks;
    logic [7:0]        bounce_left;
    logic [CODE_W-1:0] held_code;
    logic [CODE_W-1:0] code_fifo [QUEUE_DEPTH];
    logic [QPTR_W-1:0] fifo_wr;
    logic [QPTR_W-1:0] fifo_rd;
    logic [QCNT_W-1:0] fifo_level;

    t_key_report pending_reports[$];

    bit          steady;
    logic [15:0] held_pattern;
    int          errors;
    int          cycles;
    int          tick_requests;
    int          read_requests;
    int          codes_popped;
    int          drops_seen;
    int          settings_applied;

    function automatic logic [CODE_W-1:0] map_code(int pos);
        logic [CFG_W-1:0] word;
        word = (pos < 8) ? cfg_map_lo : cfg_map_hi;
        return word[(pos % 8) * 8 +: 8];
    endfunction

    // A pressed key with a zero code closes its column; the next column
    // is still searched from its first row.
    function automatic logic [CODE_W-1:0] first_key(logic [15:0] snap);
        logic [CODE_W-1:0] found;
        logic [CODE_W-1:0] code;
        bit col_done;
        int pos;
        found = '0;
        for (int c = 0; c < COLS; c++) begin
            col_done = 1'b0;
            for (int r = 0; r < ROWS; r++) begin
                pos = c * ROWS + r;
                if (found == 0 && !col_done && pos < KEYS && snap[pos]) begin
                    code = map_code(pos);
                    if (code != 0)
                        found = code;
                    col_done = 1'b1;
                end
            end
        end
        return found;
    endfunction

    function automatic bit queue_code(logic [CODE_W-1:0] code);
        if (fifo_level >= QUEUE_DEPTH)
            return 1'b0;
        code_fifo[fifo_wr] = code;
        fifo_wr = fifo_wr + 1'b1;
        fifo_level = fifo_level + 1'b1;
        return 1'b1;
    endfunction

    function automatic t_key_report step_keypad(logic act, logic [15:0] snap);
        t_key_report rep;
        logic [CODE_W-1:0] key;
        rep = '0;
        if (act == ACT_READ) begin
            if (fifo_level != 0) begin
                rep.key_code = code_fifo[fifo_rd];
                rep.key_valid = 1'b1;
                fifo_rd = fifo_rd + 1'b1;
                fifo_level = fifo_level - 1'b1;
            end
        end else begin
            scan_ticks = scan_ticks - 8'd1;
            if (scan_ticks == 0) begin
                scan_ticks = cfg_poll;
                key = first_key(snap);
                if (key == 0) begin
                    if (bounce_left != 0) begin
                        bounce_left = bounce_left - 8'd1;
                        if (bounce_left == 0) begin
                            if (cfg_release) begin
                                if (!queue_code(held_code | RELEASE_FLAG))
                                    rep.overflow = 1'b1;
                            end
                            held_code = '0;
                        end
                    end
                end else begin
                    bounce_left = cfg_debounce;
                    if (held_code != key) begin
                        held_code = key;
                        if (!queue_code(key))
                            rep.overflow = 1'b1;
                    end
                end
            end
        end
        rep.queue_count = fifo_level;
        return rep;
    endfunction

    // Predicts on each accepted request and checks each accepted result.
    always @(posedge i_clk) begin
        t_key_report want;
        if (i_rst_n && key_in.valid && key_in.ready) begin
            if (key_in.action == ACT_READ)
                read_requests++;
            else
                tick_requests++;
            pending_reports.push_back(step_keypad(key_in.action, key_in.key_matrix));
        end
        if (i_rst_n && key_out.valid && key_out.ready) begin
            if (pending_reports.size() == 0) begin
                $error("result arrived with no request outstanding");
                errors++;
            end else begin
                want = pending_reports.pop_front();
                if (want.key_valid)
                    codes_popped++;
                if (want.overflow)
                    drops_seen++;
                if (key_out.key_code !== want.key_code) begin
                    $error("key_code: expected %0h, got %0h", want.key_code, key_out.key_code);
                    errors++;
                end
                if (key_out.key_valid !== want.key_valid) begin
                    $error("key_valid: expected %0d, got %0d", want.key_valid,
                           key_out.key_valid);
                    errors++;
                end
                if (key_out.queue_count !== want.queue_count) begin
                    $error("queue_count: expected %0d, got %0d", want.queue_count,
                           key_out.queue_count);
                    errors++;
                end
                if (key_out.overflow !== want.overflow) begin
                    $error("overflow: expected %0d, got %0d", want.overflow, key_out.overflow);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        key_out.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Leaves valid high after acceptance so back-to-back requests never
    // drop it within a time step.
    task automatic send_request(logic act, logic [15:0] snap);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            @(negedge i_clk);
            key_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        key_in.valid      <= 1'b1;
        key_in.action     <= act;
        key_in.key_matrix <= snap;
        do @(posedge i_clk); while (!(key_in.valid && key_in.ready));
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        @(negedge i_clk);
        key_in.valid <= 1'b0;
        while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_POLL_PERIOD:    cfg_poll     = data[7:0];
            REG_DEBOUNCE_POLLS: cfg_debounce = data[7:0];
            REG_RELEASE_EVENTS: cfg_release  = data[0];
            REG_KEYMAP_LOW:     cfg_map_lo   = data;
            REG_KEYMAP_HIGH:    cfg_map_hi   = data;
            default: ;
        endcase
    endtask

    // Upper bits of the narrow registers get random junk to show they are unused.
    task automatic program_regs(logic [7:0] poll, logic [7:0] deb, logic rel,
                                logic [CFG_W-1:0] map_lo, logic [CFG_W-1:0] map_hi);
        drain_results();
        write_reg(REG_POLL_PERIOD,    {$urandom, $urandom} & ~64'hFF | 64'(poll));
        write_reg(REG_DEBOUNCE_POLLS, {$urandom, $urandom} & ~64'hFF | 64'(deb));
        write_reg(REG_RELEASE_EVENTS, {$urandom, $urandom} & ~64'd1 | 64'(rel));
        write_reg(REG_KEYMAP_LOW,     map_lo);
        write_reg(REG_KEYMAP_HIGH,    map_hi);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    function automatic logic [CFG_W-1:0] random_keymap();
        logic [CFG_W-1:0] w;
        for (int b = 0; b < 8; b++)
            w[8 * b +: 8] = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
        return w;
    endfunction

    function automatic logic [15:0] pick_pattern();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return 16'h0000;
        if (r < 65)
            return 16'h0001 << $urandom_range(0, 15);
        if (r < 80)
            return 16'($urandom_range(0, 16'hFFFF));
        if (r < 92)
            return (16'h0001 << $urandom_range(0, 15)) | (16'h0001 << $urandom_range(0, 15));
        return 16'hFFFF;
    endfunction

    // Mostly keys held over several scans and then let go; a few ticks
    // carry a random snapshot, like contact bounce.
    task automatic run_traffic(int read_pct, int count);
        logic [15:0] snap;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < read_pct) begin
                send_request(ACT_READ, 16'($urandom_range(0, 16'hFFFF)));
            end else begin
                if ($urandom_range(0, 99) < 20)
                    held_pattern = pick_pattern();
                snap = held_pattern;
                if ($urandom_range(0, 99) < 8)
                    snap = 16'($urandom_range(0, 16'hFFFF));
                send_request(ACT_TICK, snap);
            end
        end
    endtask

    task automatic test_power_on_defaults();
        send_request(ACT_READ, 16'hFFFF);
        repeat (10) send_request(ACT_TICK, 16'h8000);
        send_request(ACT_READ, 16'h0000);
    endtask

    task automatic test_directed_cases();
        program_regs(8'd1, 8'd2, 1'b1, 64'hFF06050403020100, 64'h7F0F0E0D0C0B0A80);
        write_reg(REG_UNUSED, {$urandom, $urandom});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        // Position 0 has a zero code, so column 0 gives nothing.
        send_request(ACT_TICK, 16'h0003);
        send_request(ACT_TICK, 16'h0013);
        send_request(ACT_TICK, 16'h0013);
        send_request(ACT_TICK, 16'h8000);
        send_request(ACT_TICK, 16'h0080);
        send_request(ACT_TICK, 16'h0100);
        send_request(ACT_TICK, 16'h0000);
        send_request(ACT_TICK, 16'h0000);
        repeat (5) send_request(ACT_READ, 16'h0000);
        send_request(ACT_READ, 16'hFFFF);
        // With a zero debounce the held key never releases.
        program_regs(8'd1, 8'd0, 1'b0, RST_KEYMAP_LOW, RST_KEYMAP_HIGH);
        send_request(ACT_TICK, 16'h0002);
        send_request(ACT_TICK, 16'h0000);
        send_request(ACT_TICK, 16'h0000);
        send_request(ACT_TICK, 16'h0002);
        send_request(ACT_READ, 16'h0000);
        send_request(ACT_READ, 16'h0000);
    endtask

    task automatic test_random_settings();
        int per_phase;
        per_phase = 46;
        for (int p = 0; p < 9; p++) begin
            steady = (p == 4);
            case (p)
                0: begin
                    program_regs(RST_POLL_PERIOD, RST_DEBOUNCE_POLLS, RST_RELEASE_EVENTS,
                                 RST_KEYMAP_LOW, RST_KEYMAP_HIGH);
                    run_traffic(20, per_phase);
                end
                1: begin
                    program_regs(8'd1, 8'd1, 1'b1, random_keymap(), random_keymap());
                    run_traffic(30, per_phase);
                end
                2: begin
                    // Few reads, so the queue fills and codes are dropped.
                    program_regs(8'd2, 8'd3, 1'b0, random_keymap(), random_keymap());
                    run_traffic(8, per_phase);
                end
                3: begin
                    program_regs(8'd3, 8'd2, 1'b1, random_keymap(), random_keymap());
                    run_traffic(40, per_phase);
                end
                4: begin
                    program_regs(8'd1, 8'd1, 1'b1, random_keymap(), random_keymap());
                    run_traffic(5, per_phase);
                end
                5: begin
                    program_regs(8'($urandom_range(1, 8)), 8'($urandom_range(0, 6)),
                                 1'($urandom_range(0, 1)), random_keymap(), random_keymap());
                    run_traffic(25, per_phase);
                end
                6: begin
                    program_regs(8'd1, 8'd255, 1'b1, random_keymap(), random_keymap());
                    run_traffic(20, per_phase);
                end
                7: begin
                    program_regs(8'd1, 8'd1, 1'b1, 64'h0, 64'hFFFFFFFFFFFFFFFF);
                    run_traffic(20, per_phase);
                end
                default: begin
                    program_regs(8'd255, 8'd255, 1'b1, random_keymap(), random_keymap());
                    run_traffic(25, per_phase);
                end
            endcase
        end
        steady = 1'b0;
    endtask

    // A zero poll period gives 256 ticks between scans. The preceding test
    // leaves the tick counter at one, so the first tick scans at once and
    // the next scan comes 256 ticks later, after the key has been let go.
    task automatic test_zero_poll_period();
        program_regs(8'd0, 8'd1, 1'b1, RST_KEYMAP_LOW, RST_KEYMAP_HIGH);
        held_pattern = 16'h0001 << $urandom_range(0, 15);
        for (int k = 0; k < 300; k++) begin
            if ($urandom_range(0, 99) < 5)
                send_request(ACT_READ, 16'($urandom_range(0, 16'hFFFF)));
            else
                send_request(ACT_TICK, (k < 240) ? held_pattern : 16'h0000);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        key_in.valid = 1'b0;
        key_in.action = ACT_TICK;
        key_in.key_matrix = '0;
        key_out.ready = 1'b0;
        steady = 1'b0;
        held_pattern = '0;
        cfg_poll = RST_POLL_PERIOD;
        cfg_debounce = RST_DEBOUNCE_POLLS;
        cfg_release = RST_RELEASE_EVENTS;
        cfg_map_lo = RST_KEYMAP_LOW;
        cfg_map_hi = RST_KEYMAP_HIGH;
        scan_ticks = RST_POLL_PERIOD;
        bounce_left = '0;
        held_code = '0;
        fifo_wr = '0;
        fifo_rd = '0;
        fifo_level = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_power_on_defaults();
        test_directed_cases();
        test_zero_poll_period();
        test_random_settings();

        drain_results();
        if (pending_reports.size() != 0) begin
            $error("%0d results never arrived", pending_reports.size());
            errors++;
        end
        $display("Ran %0d ticks and %0d reads over %0d register settings.",
                 tick_requests, read_requests, settings_applied + 1);
        $display("Codes popped: %0d, ticks with a dropped code: %0d.",
                 codes_popped, drops_seen);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/kpsd_pkg.sv
sv/kpsd_in_if.sv
sv/kpsd_out_if.sv
sv/kpsd_front.sv
sv/kpsd_cmd_fifo.sv
sv/kpsd_back.sv
sv/keypad_scan_debounce_fifo.sv
tb/keypad_scan_debounce_fifo_tb.sv
